// ===== src/pswu_pkg.sv =====
// Shared types, constants and arithmetic helpers for the particle swarm update engine.
// No dependencies; every other source file refers to it by scoped names.
package pswu_pkg;

    localparam int OP_W   = 2;
    localparam int PID_W  = 5;
    localparam int DIM_W  = 4;
    localparam int Q_W    = 32;
    localparam int WT_W   = 20;
    localparam int RND_W  = 16;
    localparam int ADIM_W = 5;
    localparam int BSEL_W = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [WT_W-1:0]   RST_INERTIA = 20'd62259;
    localparam logic [WT_W-1:0]   RST_GPULL   = 20'd131072;
    localparam logic [WT_W-1:0]   RST_LPULL   = 20'd131072;
    localparam logic [WT_W-1:0]   RST_VSCALE  = 20'd6554;
    localparam logic [ADIM_W-1:0] RST_ADIMS   = 5'd16;

    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_MOVE   = 2'd1,
        OP_REPORT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CFG_INERTIA = 3'd0,
        CFG_GPULL   = 3'd1,
        CFG_LPULL   = 3'd2,
        CFG_VSCALE  = 3'd3,
        CFG_BSEL    = 3'd4,
        CFG_BLOW    = 3'd5,
        CFG_BHIGH   = 3'd6,
        CFG_ADIMS   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [WT_W-1:0]   inertia;
        logic [WT_W-1:0]   gpull;
        logic [WT_W-1:0]   lpull;
        logic [WT_W-1:0]   vscale;
        logic [ADIM_W-1:0] adims;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [PID_W-1:0] pid;
        logic [DIM_W-1:0] dim;
        logic [Q_W-1:0]   coord;
        logic [Q_W-1:0]   fit;
        logic [Q_W-1:0]   vinit;
        logic [WT_W-1:0]  gf;
        logic [WT_W-1:0]  lf;
    } t_cmd;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return $signed(Q_MAX);
        end else if (v < lo) begin
            return $signed(Q_MIN);
        end
        return v[Q_W-1:0];
    endfunction

endpackage

// ===== src/pswu_if.sv =====
// Valid/ready channel interfaces for the item input and the coordinate output.
// Depends on pswu_pkg for field widths.
interface pswu_in_if;
    logic                              valid;
    logic                              ready;
    logic [pswu_pkg::OP_W-1:0]         operation;
    logic [pswu_pkg::PID_W-1:0]        particle_id;
    logic [pswu_pkg::DIM_W-1:0]        dim_index;
    logic signed [pswu_pkg::Q_W-1:0]   coord_value;
    logic signed [pswu_pkg::Q_W-1:0]   aux_point;
    logic signed [pswu_pkg::Q_W-1:0]   fitness_value;
    logic [pswu_pkg::RND_W-1:0]        rand_global;
    logic [pswu_pkg::RND_W-1:0]        rand_local;

    modport source (output valid, operation, particle_id, dim_index, coord_value, aux_point,
                    fitness_value, rand_global, rand_local, input ready);
    modport sink (input valid, operation, particle_id, dim_index, coord_value, aux_point,
                  fitness_value, rand_global, rand_local, output ready);
endinterface

interface pswu_out_if;
    logic                              valid;
    logic                              ready;
    logic [pswu_pkg::PID_W-1:0]        out_particle;
    logic [pswu_pkg::DIM_W-1:0]        out_dim;
    logic signed [pswu_pkg::Q_W-1:0]   out_position;
    logic                              last_coord;

    modport source (output valid, out_particle, out_dim, out_position, last_coord, input ready);
    modport sink (input valid, out_particle, out_dim, out_position, last_coord, output ready);
endinterface

// ===== src/particle_swarm_update_engine_top.sv =====
// Top level of the particle swarm update engine: APB register file, bound tables, assembly.
// Depends on pswu_pkg, pswu_if, pswu_front, pswu_queue and pswu_back.
//
// Init and report items execute once they reach the head of the two-entry command queue; a report
// on dimension 0 also passes through a fitness compare state, as it reads the personal best fitness
// memory first. A move streams one coordinate per cycle while the output does not stall, through a
// five-stage datapath (store read, differences, three parallel multipliers, saturating sum, clamp
// and write-back); the next item starts once write-back has drained. Output back-pressure stalls
// the whole datapath. After reset a clearing pass writes all 2^(clog2(SWARM_SIZE) + clog2(MAX_DIMS))
// entries (512 at the defaults) of the position, velocity and personal best stores, one entry a
// cycle, and resets the personal best fitness; no item is taken meanwhile, register writes are.
module particle_swarm_update_engine_top #(
    parameter int SWARM_SIZE = 32,
    parameter int MAX_DIMS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pswu_in_if.sink     i_in,
    pswu_out_if.source  o_out
);

    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic [pswu_pkg::WT_W-1:0]   r_inertia;
    logic [pswu_pkg::WT_W-1:0]   r_gpull;
    logic [pswu_pkg::WT_W-1:0]   r_lpull;
    logic [pswu_pkg::WT_W-1:0]   r_vscale;
    logic [pswu_pkg::BSEL_W-1:0] r_bsel;
    logic signed [31:0]          r_blow;
    logic signed [31:0]          r_bhigh;
    logic [pswu_pkg::ADIM_W-1:0] r_adims;
    logic signed [31:0]          r_lo_tab [MAX_DIMS];
    logic signed [31:0]          r_hi_tab [MAX_DIMS];

    logic                 w_wr;
    pswu_pkg::t_cfg_idx   w_idx;
    logic [7:0]           w_bsel_x;
    logic                 w_bsel_ok;
    pswu_pkg::t_cfg       w_cfg;
    logic                 w_push;
    pswu_pkg::t_cmd       w_push_cmd;
    logic                 w_q_valid;
    logic                 w_q_full;
    pswu_pkg::t_cmd       w_q_cmd;
    logic                 w_pop;
    logic                 w_clearing;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_idx     = pswu_pkg::t_cfg_idx'(paddr[4:2]);
    assign w_bsel_x  = 8'(r_bsel);
    assign w_bsel_ok = 32'(r_bsel) < MAX_DIMS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia <= pswu_pkg::RST_INERTIA;
            r_gpull   <= pswu_pkg::RST_GPULL;
            r_lpull   <= pswu_pkg::RST_LPULL;
            r_vscale  <= pswu_pkg::RST_VSCALE;
            r_bsel    <= '0;
            r_blow    <= $signed(pswu_pkg::Q_MIN);
            r_bhigh   <= $signed(pswu_pkg::Q_MAX);
            r_adims   <= pswu_pkg::RST_ADIMS;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_lo_tab[d] <= $signed(pswu_pkg::Q_MIN);
                r_hi_tab[d] <= $signed(pswu_pkg::Q_MAX);
            end
        end else if (w_wr) begin
            unique case (w_idx)
                pswu_pkg::CFG_INERTIA: r_inertia <= pwdata[pswu_pkg::WT_W-1:0];
                pswu_pkg::CFG_GPULL:   r_gpull   <= pwdata[pswu_pkg::WT_W-1:0];
                pswu_pkg::CFG_LPULL:   r_lpull   <= pwdata[pswu_pkg::WT_W-1:0];
                pswu_pkg::CFG_VSCALE:  r_vscale  <= pwdata[pswu_pkg::WT_W-1:0];
                pswu_pkg::CFG_BSEL:    r_bsel    <= pwdata[pswu_pkg::BSEL_W-1:0];
                pswu_pkg::CFG_BLOW: begin
                    r_blow <= $signed(pwdata);
                    if (w_bsel_ok) begin
                        r_lo_tab[w_bsel_x[DW-1:0]] <= $signed(pwdata);
                    end
                end
                pswu_pkg::CFG_BHIGH: begin
                    r_bhigh <= $signed(pwdata);
                    if (w_bsel_ok) begin
                        r_hi_tab[w_bsel_x[DW-1:0]] <= $signed(pwdata);
                    end
                end
                pswu_pkg::CFG_ADIMS:   r_adims   <= pwdata[pswu_pkg::ADIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pswu_pkg::CFG_INERTIA: prdata = 32'(r_inertia);
            pswu_pkg::CFG_GPULL:   prdata = 32'(r_gpull);
            pswu_pkg::CFG_LPULL:   prdata = 32'(r_lpull);
            pswu_pkg::CFG_VSCALE:  prdata = 32'(r_vscale);
            pswu_pkg::CFG_BSEL:    prdata = 32'(r_bsel);
            pswu_pkg::CFG_BLOW:    prdata = r_blow;
            pswu_pkg::CFG_BHIGH:   prdata = r_bhigh;
            pswu_pkg::CFG_ADIMS:   prdata = 32'(r_adims);
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.inertia = r_inertia;
        w_cfg.gpull   = r_gpull;
        w_cfg.lpull   = r_lpull;
        w_cfg.vscale  = r_vscale;
        w_cfg.adims   = r_adims;
    end

    pswu_front #(
        .SWARM_SIZE (SWARM_SIZE),
        .MAX_DIMS   (MAX_DIMS)
    ) u_front (
        .i_cfg      (w_cfg),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .i_in       (i_in),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    pswu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_cmd   (w_q_cmd)
    );

    pswu_back #(
        .SWARM_SIZE (SWARM_SIZE),
        .MAX_DIMS   (MAX_DIMS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_lo_tab   (r_lo_tab),
        .i_hi_tab   (r_hi_tab),
        .i_q_valid  (w_q_valid),
        .i_q_cmd    (w_q_cmd),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_out      (o_out)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !(i_in.valid && i_in.ready))
        else $error("item accepted during clearing pass");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("queue pushed while full");

endmodule

// ===== src/pswu_front.sv =====
// Front end: accepts items, drops out-of-range ones, precomputes start velocity and pull factors.
// Depends on pswu_pkg and pswu_in_if.
module pswu_front #(
    parameter int SWARM_SIZE = 32,
    parameter int MAX_DIMS   = 16
) (
    input  pswu_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    input  logic            i_clearing,
    pswu_in_if.sink         i_in,
    output logic            o_push,
    output pswu_pkg::t_cmd  o_cmd
);

    logic               w_keep;
    logic               w_in_range;
    logic signed [32:0] w_diff;
    logic signed [53:0] w_vprod;
    logic signed [53:0] w_vsh;
    logic [35:0]        w_gprod;
    logic [35:0]        w_lprod;

    assign i_in.ready = !i_q_full && !i_clearing;

    assign w_in_range = (32'(i_in.particle_id) < SWARM_SIZE) && (32'(i_in.dim_index) < MAX_DIMS);

    always_comb begin
        unique case (i_in.operation)
            pswu_pkg::OP_MOVE:                      w_keep = 1'b1;
            pswu_pkg::OP_INIT, pswu_pkg::OP_REPORT: w_keep = w_in_range;
            default:                                w_keep = 1'b0;
        endcase
    end

    assign o_push = i_in.valid && i_in.ready && w_keep;

    assign w_diff  = 33'(i_in.coord_value) - 33'(i_in.aux_point);
    assign w_vprod = 54'(w_diff) * 54'($signed({1'b0, i_cfg.vscale}));
    assign w_vsh   = w_vprod >>> 16;
    assign w_gprod = 36'(i_cfg.gpull) * 36'(i_in.rand_global);
    assign w_lprod = 36'(i_cfg.lpull) * 36'(i_in.rand_local);

    always_comb begin
        o_cmd.op    = pswu_pkg::t_op'(i_in.operation);
        o_cmd.pid   = i_in.particle_id;
        o_cmd.dim   = i_in.dim_index;
        o_cmd.coord = i_in.coord_value;
        o_cmd.fit   = i_in.fitness_value;
        o_cmd.vinit = pswu_pkg::sat32(64'(w_vsh));
        o_cmd.gf    = w_gprod[35:16];
        o_cmd.lf    = w_lprod[35:16];
    end

endmodule

// ===== src/pswu_queue.sv =====
// Short command queue between front end and execution side.
// Depends on pswu_pkg.
module pswu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pswu_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output pswu_pkg::t_cmd o_cmd
);

    pswu_pkg::t_cmd                r_mem [pswu_pkg::QUEUE_DEPTH];
    logic [pswu_pkg::QPTR_W-1:0]   r_wp;
    logic [pswu_pkg::QPTR_W-1:0]   r_rp;
    logic [pswu_pkg::QPTR_W:0]     r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (pswu_pkg::QPTR_W + 1)'(pswu_pkg::QUEUE_DEPTH);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== src/pswu_back.sv =====
// Execution side: particle stores, best tracking, and the five-stage move datapath.
// Depends on pswu_pkg and pswu_out_if.
module pswu_back #(
    parameter int SWARM_SIZE = 32,
    parameter int MAX_DIMS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pswu_pkg::t_cfg       i_cfg,
    input  logic signed [31:0]   i_lo_tab [MAX_DIMS],
    input  logic signed [31:0]   i_hi_tab [MAX_DIMS],
    input  logic                 i_q_valid,
    input  pswu_pkg::t_cmd       i_q_cmd,
    output logic                 o_pop,
    output logic                 o_clearing,
    pswu_out_if.source           o_out
);

    localparam int PW    = $clog2(SWARM_SIZE);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW    = PW + DW;
    localparam int DEPTH = 1 << AW;
    localparam int NP    = 1 << PW;
    localparam int CW    = $clog2(MAX_DIMS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOVE  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIT   = 5'b10000
    } t_bstate;

    logic [31:0] mem_pos [DEPTH];
    logic [31:0] mem_vel [DEPTH];
    logic [31:0] mem_pb  [DEPTH];
    logic [31:0] mem_fit [NP];

    t_bstate             r_state;
    logic [AW-1:0]       r_clr_cnt;
    logic [PW-1:0]       r_next_p;
    logic [PW-1:0]       r_p;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_n;
    logic [19:0]         r_gf;
    logic [19:0]         r_lf;
    logic                r_tp;
    logic                r_ts;
    logic signed [31:0]  r_sbf;
    logic signed [31:0]  r_sb [MAX_DIMS];
    pswu_pkg::t_cmd      r_cmd;
    logic [31:0]         r_rd_fit;

    logic [31:0]         r_rd_pos;
    logic [31:0]         r_rd_vel;
    logic [31:0]         r_rd_pb;
    logic                r_s1_v;
    logic [DW-1:0]       r_s1_j;
    logic                r_s1_last;
    logic                r_s2_v;
    logic [DW-1:0]       r_s2_j;
    logic                r_s2_last;
    logic signed [31:0]  r_s2_pos;
    logic signed [31:0]  r_s2_vel;
    logic signed [32:0]  r_s2_dg;
    logic signed [32:0]  r_s2_dl;
    logic                r_s3_v;
    logic [DW-1:0]       r_s3_j;
    logic                r_s3_last;
    logic signed [31:0]  r_s3_pos;
    logic signed [53:0]  r_s3_mv;
    logic signed [53:0]  r_s3_gp;
    logic signed [53:0]  r_s3_lp;
    logic                r_s4_v;
    logic [DW-1:0]       r_s4_j;
    logic                r_s4_last;
    logic signed [31:0]  r_s4_pos;
    logic signed [31:0]  r_s4_vel;
    logic                r_ov;
    logic [pswu_pkg::PID_W-1:0] r_o_p;
    logic [pswu_pkg::DIM_W-1:0] r_o_dim;
    logic signed [31:0]  r_o_pos;
    logic                r_o_last;

    t_bstate             n_state;
    logic                w_adv;
    logic                w_issue;
    logic                w_last_issue;
    logic [10:0]         w_hpid_x;
    logic [5:0]          w_hdim_x;
    logic [PW-1:0]       w_hpid;
    logic [DW-1:0]       w_hdim;
    logic [10:0]         w_cpid_x;
    logic [PW-1:0]       w_cpid;
    logic [CW-1:0]       w_n;
    logic [AW-1:0]       w_rd_addr;
    logic                w_pos_we;
    logic                w_vel_we;
    logic                w_pb_we;
    logic                w_fit_we;
    logic [AW-1:0]       w_pos_wa;
    logic [AW-1:0]       w_pb_wa;
    logic [PW-1:0]       w_fit_wa;
    logic [31:0]         w_pos_wd;
    logic [31:0]         w_vel_wd;
    logic [31:0]         w_pb_wd;
    logic [31:0]         w_fit_wd;
    logic                w_tp;
    logic                w_ts;
    logic signed [31:0]  w_s1_sb;
    logic signed [31:0]  w_s3_v;
    logic signed [32:0]  w_s4_sum;
    logic signed [31:0]  w_s4_hi;
    logic signed [31:0]  w_s4_lo;
    logic signed [31:0]  w_s4_npos;
    logic signed [31:0]  w_s4_nvel;
    logic [10:0]         w_p_x;
    logic [5:0]          w_j_x;

    assign o_clearing = r_state == ST_CLEAR;
    assign w_adv      = !r_ov || o_out.ready;
    assign w_issue    = (r_state == ST_MOVE) && w_adv;
    assign w_last_issue = (r_j + 1'b1) == r_n;
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;

    assign w_hpid_x = 11'(i_q_cmd.pid);
    assign w_hdim_x = 6'(i_q_cmd.dim);
    assign w_hpid   = w_hpid_x[PW-1:0];
    assign w_hdim   = w_hdim_x[DW-1:0];
    assign w_cpid_x = 11'(r_cmd.pid);
    assign w_cpid   = w_cpid_x[PW-1:0];
    assign w_rd_addr = {r_p, r_j[DW-1:0]};

    always_comb begin
        if (i_cfg.adims == '0) begin
            w_n = CW'(1);
        end else if (32'(i_cfg.adims) > MAX_DIMS) begin
            w_n = CW'(MAX_DIMS);
        end else begin
            w_n = CW'(i_cfg.adims);
        end
    end

    assign w_tp = $signed(r_cmd.fit) > $signed(r_rd_fit);
    assign w_ts = $signed(r_cmd.fit) > r_sbf;

    // single write port per store; users never overlap in time
    always_comb begin
        w_pos_we = 1'b0;
        w_vel_we = 1'b0;
        w_pb_we  = 1'b0;
        w_fit_we = 1'b0;
        w_pos_wa = {w_hpid, w_hdim};
        w_pb_wa  = {w_hpid, w_hdim};
        w_fit_wa = w_cpid;
        w_pos_wd = i_q_cmd.coord;
        w_vel_wd = i_q_cmd.vinit;
        w_pb_wd  = i_q_cmd.coord;
        w_fit_wd = r_cmd.fit;
        if (r_state == ST_CLEAR) begin
            w_pos_we = 1'b1;
            w_vel_we = 1'b1;
            w_pb_we  = 1'b1;
            w_fit_we = 1'b1;
            w_pos_wa = r_clr_cnt;
            w_pb_wa  = r_clr_cnt;
            w_fit_wa = r_clr_cnt[AW-1:DW];
            w_pos_wd = '0;
            w_vel_wd = '0;
            w_pb_wd  = '0;
            w_fit_wd = pswu_pkg::Q_MIN;
        end else if (r_state == ST_FIT) begin
            w_pb_we  = w_tp;
            w_fit_we = w_tp;
            w_pb_wa  = {w_cpid, DW'(0)};
            w_pb_wd  = r_cmd.coord;
        end else if (r_s4_v && w_adv) begin
            w_pos_we = 1'b1;
            w_vel_we = 1'b1;
            w_pos_wa = {r_p, r_s4_j};
            w_pos_wd = w_s4_npos;
            w_vel_wd = w_s4_nvel;
        end else if (o_pop) begin
            case (i_q_cmd.op)
                pswu_pkg::OP_INIT: begin
                    w_pos_we = 1'b1;
                    w_vel_we = 1'b1;
                    w_pb_we  = 1'b1;
                end
                pswu_pkg::OP_REPORT: begin
                    w_pb_we = r_tp && (i_q_cmd.dim != '0);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            mem_pos[w_pos_wa] <= w_pos_wd;
        end
        if (w_vel_we) begin
            mem_vel[w_pos_wa] <= w_vel_wd;
        end
        if (w_pb_we) begin
            mem_pb[w_pb_wa] <= w_pb_wd;
        end
        if (w_fit_we) begin
            mem_fit[w_fit_wa] <= w_fit_wd;
        end
        r_rd_fit <= mem_fit[w_hpid];
        if (w_adv) begin
            r_rd_pos <= mem_pos[w_rd_addr];
            r_rd_vel <= mem_vel[w_rd_addr];
            r_rd_pb  <= mem_pb[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop && (i_q_cmd.op == pswu_pkg::OP_MOVE)) begin
                    n_state = ST_MOVE;
                end else if (o_pop && (i_q_cmd.op == pswu_pkg::OP_REPORT)
                             && (i_q_cmd.dim == '0)) begin
                    n_state = ST_FIT;
                end
            end
            ST_MOVE: begin
                if (w_issue && w_last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_next_p  <= '0;
            r_tp      <= 1'b0;
            r_ts      <= 1'b0;
            r_sbf     <= $signed(pswu_pkg::Q_MIN);
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_sb[d] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (o_pop && (i_q_cmd.op == pswu_pkg::OP_MOVE)) begin
                r_next_p <= (r_next_p == PW'(SWARM_SIZE - 1)) ? '0 : r_next_p + 1'b1;
            end
            if (o_pop && (i_q_cmd.op == pswu_pkg::OP_REPORT) && (i_q_cmd.dim != '0)
                && r_ts) begin
                r_sb[w_hdim] <= $signed(i_q_cmd.coord);
            end
            if (r_state == ST_FIT) begin
                r_tp <= w_tp;
                r_ts <= w_ts;
                if (w_ts) begin
                    r_sbf   <= $signed(r_cmd.fit);
                    r_sb[0] <= $signed(r_cmd.coord);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (o_pop && (i_q_cmd.op == pswu_pkg::OP_MOVE)) begin
            r_p  <= r_next_p;
            r_j  <= '0;
            r_n  <= w_n;
            r_gf <= i_q_cmd.gf;
            r_lf <= i_q_cmd.lf;
        end else if (w_issue) begin
            r_j <= r_j + 1'b1;
        end
    end

    assign w_s1_sb  = r_sb[r_s1_j];
    assign w_s3_v   = pswu_pkg::sat32(64'(pswu_pkg::sat32(64'(r_s3_mv >>> 16)))
                                    + 64'(pswu_pkg::sat32(64'(r_s3_gp >>> 16)))
                                    + 64'(pswu_pkg::sat32(64'(r_s3_lp >>> 16))));
    assign w_s4_hi  = i_hi_tab[r_s4_j];
    assign w_s4_lo  = i_lo_tab[r_s4_j];
    assign w_s4_sum = 33'(r_s4_pos) + 33'(r_s4_vel);

    always_comb begin
        if (w_s4_sum > 33'(w_s4_hi)) begin
            w_s4_npos = w_s4_hi;
            w_s4_nvel = pswu_pkg::sat32(64'(w_s4_hi) - 64'(r_s4_pos));
        end else if (w_s4_sum < 33'(w_s4_lo)) begin
            w_s4_npos = w_s4_lo;
            w_s4_nvel = pswu_pkg::sat32(64'(r_s4_pos) - 64'(w_s4_lo));
        end else begin
            w_s4_npos = w_s4_sum[31:0];
            w_s4_nvel = r_s4_vel;
        end
    end

    assign w_p_x = 11'(r_p);
    assign w_j_x = 6'(r_s4_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_ov   <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_j    <= r_j[DW-1:0];
            r_s1_last <= w_last_issue;

            r_s2_j    <= r_s1_j;
            r_s2_last <= r_s1_last;
            r_s2_pos  <= $signed(r_rd_pos);
            r_s2_vel  <= $signed(r_rd_vel);
            r_s2_dg   <= 33'(w_s1_sb) - 33'($signed(r_rd_pos));
            r_s2_dl   <= 33'($signed(r_rd_pb)) - 33'($signed(r_rd_pos));

            r_s3_j    <= r_s2_j;
            r_s3_last <= r_s2_last;
            r_s3_pos  <= r_s2_pos;
            r_s3_mv   <= 54'(r_s2_vel) * 54'($signed({1'b0, i_cfg.inertia}));
            r_s3_gp   <= 54'(r_s2_dg) * 54'($signed({1'b0, r_gf}));
            r_s3_lp   <= 54'(r_s2_dl) * 54'($signed({1'b0, r_lf}));

            r_s4_j    <= r_s3_j;
            r_s4_last <= r_s3_last;
            r_s4_pos  <= r_s3_pos;
            r_s4_vel  <= w_s3_v;

            if (r_s4_v) begin
                r_o_p    <= w_p_x[pswu_pkg::PID_W-1:0];
                r_o_dim  <= w_j_x[pswu_pkg::DIM_W-1:0];
                r_o_pos  <= w_s4_npos;
                r_o_last <= r_s4_last;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_particle = r_o_p;
    assign o_out.out_dim      = r_o_dim;
    assign o_out.out_position = r_o_pos;
    assign o_out.last_coord   = r_o_last;

endmodule

// ===== sim/tb_particle_swarm_update_engine_top.sv =====
// Self-checking bench for the particle swarm update engine: directed and random items,
// APB register phases, random source bursts and sink stalls, scoreboard of expected coordinates.
// Depends on pswu_pkg, pswu_if and the engine RTL.
module tb_particle_swarm_update_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPART = 32;
    localparam int NDIM  = 16;
    localparam int LIMIT = 400000;

    typedef struct {
        pswu_pkg::t_op              op;
        logic [pswu_pkg::PID_W-1:0] pid;
        logic [pswu_pkg::DIM_W-1:0] dim;
        logic [31:0]                coord;
        logic [31:0]                aux;
        logic [31:0]                fit;
        logic [15:0]                rg;
        logic [15:0]                rl;
    } t_item;

    typedef struct {
        logic [pswu_pkg::PID_W-1:0] pid;
        logic [pswu_pkg::DIM_W-1:0] dim;
        logic [31:0]                pos;
        logic                       last;
    } t_coord;

    class swarm_scoreboard;
        longint pos_s[NPART][NDIM];
        longint vel_s[NPART][NDIM];
        longint pb_s[NPART][NDIM];
        longint pb_fit[NPART];
        longint sb_s[NDIM];
        longint sb_fit;
        longint lo_t[NDIM];
        longint hi_t[NDIM];
        longint inertia, gw, lw, vscale, bsel, adims;
        int     next_p;
        bit     take_p, take_s;
        t_coord pending[$];
        int     errors;

        function void clear();
            for (int p = 0; p < NPART; p++) begin
                for (int d = 0; d < NDIM; d++) begin
                    pos_s[p][d] = 0; vel_s[p][d] = 0; pb_s[p][d] = 0;
                end
                pb_fit[p] = -64'sd2147483648;
            end
            for (int d = 0; d < NDIM; d++) begin
                sb_s[d] = 0; lo_t[d] = -64'sd2147483648; hi_t[d] = 64'sd2147483647;
            end
            sb_fit = -64'sd2147483648;
            inertia = 62259; gw = 131072; lw = 131072; vscale = 6554; bsel = 0; adims = 16;
            next_p = 0; take_p = 0; take_s = 0; errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // product a * w, floor-divided by 2^16
        function longint scale16(longint a, longint w);
            return (a * w) >>> 16;
        endfunction

        function void write_reg(pswu_pkg::t_cfg_idx idx, logic [31:0] v);
            case (idx)
                pswu_pkg::CFG_INERTIA: inertia = v[19:0];
                pswu_pkg::CFG_GPULL:   gw = v[19:0];
                pswu_pkg::CFG_LPULL:   lw = v[19:0];
                pswu_pkg::CFG_VSCALE:  vscale = v[19:0];
                pswu_pkg::CFG_BSEL:    bsel = v[3:0];
                pswu_pkg::CFG_BLOW:    lo_t[bsel] = longint'($signed(v));
                pswu_pkg::CFG_BHIGH:   hi_t[bsel] = longint'($signed(v));
                pswu_pkg::CFG_ADIMS:   adims = v[4:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_item it);
            longint c, gf, lf, p, n, pos, mv, gp, lp, v, s;
            t_coord r;
            c = longint'($signed(it.coord));
            case (it.op)
                pswu_pkg::OP_INIT: begin
                    pos_s[it.pid][it.dim] = c;
                    pb_s[it.pid][it.dim] = c;
                    vel_s[it.pid][it.dim] =
                        clamp32(scale16(c - longint'($signed(it.aux)), vscale));
                end
                pswu_pkg::OP_REPORT: begin
                    if (it.dim == 0) begin
                        take_p = longint'($signed(it.fit)) > pb_fit[it.pid];
                        if (take_p) pb_fit[it.pid] = longint'($signed(it.fit));
                        take_s = longint'($signed(it.fit)) > sb_fit;
                        if (take_s) sb_fit = longint'($signed(it.fit));
                    end
                    if (take_p) pb_s[it.pid][it.dim] = c;
                    if (take_s) sb_s[it.dim] = c;
                end
                pswu_pkg::OP_MOVE: begin
                    p = next_p;
                    n = (adims == 0) ? 1 : (adims > NDIM) ? NDIM : adims;
                    gf = (gw * it.rg) >> 16;
                    lf = (lw * it.rl) >> 16;
                    next_p = (p + 1 >= NPART) ? 0 : int'(p + 1);
                    for (int j = 0; j < n; j++) begin
                        pos = pos_s[p][j];
                        mv = clamp32(scale16(vel_s[p][j], inertia));
                        gp = clamp32(scale16(sb_s[j] - pos, gf));
                        lp = clamp32(scale16(pb_s[p][j] - pos, lf));
                        v = clamp32(mv + gp + lp);
                        s = pos + v;
                        if (s > hi_t[j]) begin
                            v = clamp32(hi_t[j] - pos); pos = hi_t[j];
                        end else if (s < lo_t[j]) begin
                            v = clamp32(pos - lo_t[j]); pos = lo_t[j];
                        end else begin
                            pos = s;
                        end
                        vel_s[p][j] = v;
                        pos_s[p][j] = pos;
                        r.pid = p[pswu_pkg::PID_W-1:0];
                        r.dim = j[pswu_pkg::DIM_W-1:0];
                        r.pos = pos[31:0];
                        r.last = (j + 1 == n);
                        pending.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_coord(t_coord a);
            t_coord e;
            if (pending.size() == 0) begin
                $error("unexpected coordinate beat pid=%0d dim=%0d", a.pid, a.dim);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.pid !== e.pid) begin
                $error("out_particle exp %0d got %0d", e.pid, a.pid); errors++;
            end
            if (a.dim !== e.dim) begin
                $error("out_dim exp %0d got %0d", e.dim, a.dim); errors++;
            end
            if (a.pos !== e.pos) begin
                $error("out_position exp %h got %h", e.pos, a.pos); errors++;
            end
            if (a.last !== e.last) begin
                $error("last_coord exp %0b got %0b", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    pswu_in_if   in_ch();
    pswu_out_if  out_ch();

    particle_swarm_update_engine_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    swarm_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  hold_sink = 0;
    bit  rand_phase = 0;
    int  move_cnt = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // coordinate sink: random stall pattern, long hold-off on request
    always @(posedge i_clk) begin
        t_coord a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a.pid = out_ch.out_particle; a.dim = out_ch.out_dim;
            a.pos = out_ch.out_position; a.last = out_ch.last_coord;
            sb.check_coord(a);
        end
    end

    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) out_ch.ready <= 0;
            else if ((cycle_cnt / 64) % 4 == 3) out_ch.ready <= 1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic apb_write(pswu_pkg::t_cfg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_item(t_item it);
        @(negedge i_clk);
        in_ch.valid <= 1;
        in_ch.operation <= it.op; in_ch.particle_id <= it.pid; in_ch.dim_index <= it.dim;
        in_ch.coord_value <= it.coord; in_ch.aux_point <= it.aux;
        in_ch.fitness_value <= it.fit; in_ch.rand_global <= it.rg; in_ch.rand_local <= it.rl;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
        if (it.op == pswu_pkg::OP_MOVE) move_cnt++;
        if (rand_phase && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_q();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 'h3F_FFFF)) - 'h20_0000);
        endcase
    endfunction

    function automatic t_item mk(pswu_pkg::t_op op, int pid, int dim);
        t_item it;
        it.op = op; it.pid = pid[pswu_pkg::PID_W-1:0]; it.dim = dim[pswu_pkg::DIM_W-1:0];
        it.coord = rnd_q(); it.aux = rnd_q(); it.fit = rnd_q();
        it.rg = 16'($urandom); it.rl = 16'($urandom);
        return it;
    endfunction

    task automatic random_phase(int n);
        t_item it;
        int    p;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(mk(pswu_pkg::OP_INIT, $urandom_range(0, 31),
                                      $urandom_range(0, 15)));
                3, 4: begin
                    // report sequence: dimension 0 first, then three reports on random nonzero dimensions
                    p = $urandom_range(0, 31);
                    send_item(mk(pswu_pkg::OP_REPORT, p, 0));
                    for (int d = 1; d < 4; d++) begin
                        send_item(mk(pswu_pkg::OP_REPORT, p, $urandom_range(1, 15)));
                    end
                    k += 3;
                end
                5: send_item(mk(pswu_pkg::OP_REPORT, $urandom_range(0, 31),
                                $urandom_range(0, 15)));
                default: send_item(mk(pswu_pkg::OP_MOVE, $urandom_range(0, 31),
                                      $urandom_range(0, 15)));
            endcase
        end
    endtask

    initial begin
        t_item it;
        sb.clear();
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.operation = pswu_pkg::OP_INIT; in_ch.particle_id = 0;
        in_ch.dim_index = 0;
        in_ch.coord_value = 0; in_ch.aux_point = 0; in_ch.fitness_value = 0;
        in_ch.rand_global = 0; in_ch.rand_local = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, every operation, out-of-range dims, crossed bounds
        apb_write(pswu_pkg::CFG_ADIMS, 4);
        apb_write(pswu_pkg::CFG_BSEL, 1);
        apb_write(pswu_pkg::CFG_BLOW, 32'h0001_0000);
        apb_write(pswu_pkg::CFG_BHIGH, 32'hFFFF_0000);
        it = mk(pswu_pkg::OP_INIT, 0, 0); it.coord = 32'h7FFF_FFFF; it.aux = 32'h8000_0000;
        send_item(it);
        it = mk(pswu_pkg::OP_INIT, 0, 1); it.coord = 32'h8000_0000; it.aux = 32'h7FFF_FFFF;
        send_item(it);
        it = mk(pswu_pkg::OP_INIT, 31, 15); send_item(it);
        it = mk(pswu_pkg::OP_REPORT, 0, 0); it.fit = 32'h8000_0000; send_item(it);
        it = mk(pswu_pkg::OP_REPORT, 0, 0); it.fit = 32'h7FFF_FFFF; it.coord = 32'h7FFF_FFFF;
        send_item(it);
        it = mk(pswu_pkg::OP_REPORT, 0, 2); it.coord = 32'h8000_0000; send_item(it);
        it = mk(pswu_pkg::OP_MOVE, 0, 0); it.rg = 16'hFFFF; it.rl = 16'hFFFF; send_item(it);
        it = mk(pswu_pkg::OP_MOVE, 0, 0); it.rg = 0; it.rl = 0; send_item(it);
        it = mk(pswu_pkg::OP_REPORT, 31, 15); it.fit = 32'h7FFF_FFFF; send_item(it);
        it = mk(pswu_pkg::OP_INIT, 0, 0); it.op = pswu_pkg::t_op'(2'd3); send_item(it);
        drain();
        apb_write(pswu_pkg::CFG_ADIMS, 0);
        apb_write(pswu_pkg::CFG_INERTIA, 20'hFFFFF);
        apb_write(pswu_pkg::CFG_GPULL, 20'hFFFFF);
        apb_write(pswu_pkg::CFG_LPULL, 0);
        apb_write(pswu_pkg::CFG_VSCALE, 20'hFFFFF);
        it = mk(pswu_pkg::OP_INIT, 2, 0); it.coord = 32'h7FFF_FFFF; it.aux = 32'h8000_0000;
        send_item(it);
        for (int k = 0; k < 3; k++) send_item(mk(pswu_pkg::OP_MOVE, 0, 0));
        drain();
        apb_write(pswu_pkg::CFG_ADIMS, 31);
        apb_write(pswu_pkg::CFG_BSEL, 0);
        apb_write(pswu_pkg::CFG_BHIGH, 32'h7FFF_FFFF);
        apb_write(pswu_pkg::CFG_BLOW, 32'h8000_0000);
        apb_write(pswu_pkg::CFG_BSEL, 1);
        apb_write(pswu_pkg::CFG_BLOW, 32'h8000_0000);
        apb_write(pswu_pkg::CFG_BHIGH, 32'h7FFF_FFFF);
        apb_write(pswu_pkg::CFG_BSEL, 15);
        apb_write(pswu_pkg::CFG_BLOW, 32'hFFF0_0000);
        apb_write(pswu_pkg::CFG_BHIGH, 32'h0010_0000);
        send_item(mk(pswu_pkg::OP_MOVE, 0, 0));

        // long sink hold-off while items keep coming
        fork
            begin
                hold_sink = 1;
                repeat (300) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 4; k++) send_item(mk(pswu_pkg::OP_MOVE, 0, 0));
        join
        drain();

        rand_phase = 1;
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(pswu_pkg::CFG_ADIMS, $urandom_range(1, 16));
            apb_write(pswu_pkg::CFG_INERTIA, $urandom_range(0, 70000));
            apb_write(pswu_pkg::CFG_GPULL, $urandom_range(0, 200000));
            apb_write(pswu_pkg::CFG_LPULL, $urandom_range(0, 200000));
            apb_write(pswu_pkg::CFG_VSCALE, $urandom_range(0, 1048575));
            apb_write(pswu_pkg::CFG_BSEL, $urandom_range(0, 15));
            apb_write(pswu_pkg::CFG_BLOW, 32'($signed($urandom_range(0, 'h40_0000)) - 'h50_0000));
            apb_write(pswu_pkg::CFG_BHIGH, 32'($urandom_range(0, 'h50_0000)));
            random_phase(23);
            drain();
        end

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
